@@ design/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
// Used by rau_iter and rational_arithmetic_unit; depends on nothing else.
package rau_pkg;

  // Width of one operand word; bit WORD_BITS-1 of an operand is its sign bit.
  localparam int WORD_BITS = 32;
  // Datapath width: a product of two magnitudes plus one bit for a sum.
  localparam int DW = 2 * WORD_BITS + 1;
  // Counter width able to hold DW itself.
  localparam int CW = $clog2(DW + 1);

  // Command codes.
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Operations of the shared iterative unit.
  typedef enum logic {
    OP_GCD = 1'b0,
    OP_DIV = 1'b1
  } unit_op_t;

  // Request from the sequencer to the iterative unit.
  typedef struct packed {
    logic     go;
    unit_op_t op;
  } unit_req_t;

endpackage

@@ design/rau_iter.sv @@
// Shared iterative unit: binary gcd or restoring division, one step a cycle.
// Depends on rau_pkg.
module rau_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::unit_req_t   req,
  input  logic [rau_pkg::DW-1:0] x,
  input  logic [rau_pkg::DW-1:0] y,
  output logic                 done,
  output logic [rau_pkg::DW-1:0] result
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_GCD  = 4'b0010,
    U_SHL  = 4'b0100,
    U_DIV  = 4'b1000
  } ustate_t;

  ustate_t        state;
  logic [DW-1:0]  u;
  logic [DW-1:0]  v;
  logic [DW-1:0]  rem;
  logic [CW-1:0]  cnt;

  // One division step: shift in the next dividend bit and try to subtract.
  logic [DW:0]    rem_sh;
  logic           fits_sub;
  logic [DW-1:0]  rem_next;
  logic [DW-1:0]  q_next;

  always_comb begin
    rem_sh   = {rem, u[DW-1]};
    fits_sub = rem_sh >= {1'b0, v};
    rem_next = fits_sub ? DW'(rem_sh - {1'b0, v}) : rem_sh[DW-1:0];
    q_next   = {u[DW-2:0], fits_sub};
  end

  // Sequencing of the gcd, the final shift and the division.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.go) begin
            u   <= x;
            v   <= y;
            rem <= '0;
            if (req.op == OP_DIV) begin
              cnt   <= CW'(DW);
              state <= U_DIV;
            end else begin
              cnt   <= '0;
              state <= U_GCD;
            end
          end
        end
        U_GCD: begin
          if (u == '0 || v == '0) begin
            u     <= u | v;
            state <= U_SHL;
          end else if (!u[0] && !v[0]) begin
            u   <= u >> 1;
            v   <= v >> 1;
            cnt <= cnt + CW'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        U_SHL: begin
          // Restore the common power of two one bit at a time.
          if (cnt == '0) begin
            result <= u;
            done   <= 1'b1;
            state  <= U_IDLE;
          end else begin
            u   <= u << 1;
            cnt <= cnt - CW'(1);
          end
        end
        U_DIV: begin
          rem <= rem_next;
          u   <= q_next;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            result <= q_next;
            done   <= 1'b1;
            state  <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

@@ design/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, multiplier, sign logic.
// Depends on rau_pkg and rau_iter.
//
// An operation is transferred in at a clock edge where start is high and busy
// is low; busy then stays high until the result has been shown. The result
// appears on res_num, res_den, is_equal and status for exactly one cycle with
// done high, and the receiver must take it in that cycle. A zero operand
// denominator finishes without any reduction; compare and divide by zero finish
// after the two operand reductions; add, subtract, multiply and divide run three
// reductions. The run time is set by the shared gcd/divide unit, which does one
// binary gcd step or one quotient bit per cycle: each reduction is a gcd plus
// its final shift, then two divisions.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               done,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               is_equal,
  output logic [1:0]         status
);
  import rau_pkg::*;

  localparam int W = WORD_BITS;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_GCD_GO = 14'b00000000000010,
    S_GCD_WT = 14'b00000000000100,
    S_DVN_GO = 14'b00000000001000,
    S_DVN_WT = 14'b00000000010000,
    S_DVD_GO = 14'b00000000100000,
    S_DVD_WT = 14'b00000001000000,
    S_STORE  = 14'b00000010000000,
    S_MUL1   = 14'b00000100000000,
    S_MUL2   = 14'b00001000000000,
    S_MUL3   = 14'b00010000000000,
    S_COMB   = 14'b00100000000000,
    S_FIN    = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_A = 3'b001,
    PH_B = 3'b010,
    PH_R = 3'b100
  } phase_t;

  state_t          state;
  phase_t          phase;
  logic [2:0]      cmd;
  logic [DW-1:0]   wn;
  logic [DW-1:0]   wd;
  logic            w_sign;
  logic [DW-1:0]   g;
  logic [DW-1:0]   t1;
  logic [DW-1:0]   t2;
  logic [W-1:0]    bn_mag;
  logic [W-1:0]    bd_mag;
  logic            b_sign;
  logic            ra_neg;
  logic [W-1:0]    ra_num;
  logic [W-1:0]    ra_den;
  logic            rb_neg;
  logic [W-1:0]    rb_num;
  logic [W-1:0]    rb_den;
  logic [1:0]      st;
  logic            eq;
  logic [31:0]     r_num;
  logic [30:0]     r_den;

  // Split the incoming words into sign and magnitude.
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;

  always_comb begin
    in_an = a_num[W-1:0];
    in_ad = a_den[W-1:0];
    in_bn = b_num[W-1:0];
    in_bd = b_den[W-1:0];
    an_m  = in_an[W-1] ? W'(-in_an) : in_an;
    ad_m  = in_ad[W-1] ? W'(-in_ad) : in_ad;
    bn_m  = in_bn[W-1] ? W'(-in_bn) : in_bn;
    bd_m  = in_bd[W-1] ? W'(-in_bd) : in_bd;
  end

  // Request to the shared unit.
  unit_req_t     req;
  logic [DW-1:0] ux;
  logic [DW-1:0] uy;
  logic          u_done;
  logic [DW-1:0] u_res;

  always_comb begin
    req.go = (state == S_GCD_GO) || (state == S_DVN_GO) || (state == S_DVD_GO);
    req.op = (state == S_GCD_GO) ? OP_GCD : OP_DIV;
    ux     = (state == S_DVD_GO) ? wd : wn;
    uy     = (state == S_GCD_GO) ? wd : g;
  end

  rau_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .x      (ux),
    .y      (uy),
    .done   (u_done),
    .result (u_res)
  );

  // Single multiplier, operands chosen by the step in progress.
  logic [W-1:0]   m_x;
  logic [W-1:0]   m_y;
  logic [2*W-1:0] m_p;

  always_comb begin
    case (state)
      S_MUL1: begin
        m_x = ra_num;
        m_y = (cmd == CMD_MUL) ? rb_num : rb_den;
      end
      S_MUL2: begin
        m_x = rb_num;
        m_y = ra_den;
      end
      default: begin
        m_x = ra_den;
        m_y = (cmd == CMD_DIV) ? rb_num : rb_den;
      end
    endcase
    m_p = m_x * m_y;
  end

  // Exact signed sum of the two cross products.
  logic          bs;
  logic          t_ge;
  logic [DW-1:0] s_mag;
  logic          s_sign;

  always_comb begin
    bs   = (cmd == CMD_SUB) ? !rb_neg : rb_neg;
    t_ge = t1 >= t2;
    if (ra_neg == bs) begin
      s_mag  = t1 + t2;
      s_sign = ra_neg;
    end else if (t_ge) begin
      s_mag  = t1 - t2;
      s_sign = ra_neg;
    end else begin
      s_mag  = t2 - t1;
      s_sign = bs;
    end
  end

  // Range check of the reduced result.
  logic [DW-1:0] half;
  logic          r_neg;
  logic          r_fits;
  logic [DW-1:0] r_sv;

  always_comb begin
    half   = DW'(1) << (W - 1);
    r_neg  = (wn != '0) && w_sign;
    r_fits = (r_neg ? (wn <= half) : (wn < half)) && (wd < half);
    r_sv   = r_neg ? DW'(-wn) : wn;
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd    <= command;
            r_num  <= '0;
            r_den  <= 31'd1;
            eq     <= 1'b0;
            st     <= ST_OK;
            bn_mag <= bn_m;
            bd_mag <= bd_m;
            b_sign <= in_bn[W-1] ^ in_bd[W-1];
            if (ad_m == '0 || bd_m == '0) begin
              st    <= ST_ZDEN;
              state <= S_FIN;
            end else begin
              wn     <= DW'(an_m);
              wd     <= DW'(ad_m);
              w_sign <= in_an[W-1] ^ in_ad[W-1];
              phase  <= PH_A;
              state  <= S_GCD_GO;
            end
          end
        end
        S_GCD_GO: state <= S_GCD_WT;
        S_GCD_WT: begin
          if (u_done) begin
            g     <= u_res;
            state <= S_DVN_GO;
          end
        end
        S_DVN_GO: state <= S_DVN_WT;
        S_DVN_WT: begin
          if (u_done) begin
            wn    <= u_res;
            state <= S_DVD_GO;
          end
        end
        S_DVD_GO: state <= S_DVD_WT;
        S_DVD_WT: begin
          if (u_done) begin
            wd    <= u_res;
            state <= S_STORE;
          end
        end
        S_STORE: begin
          case (phase)
            PH_A: begin
              ra_num <= wn[W-1:0];
              ra_den <= wd[W-1:0];
              ra_neg <= r_neg;
              wn     <= DW'(bn_mag);
              wd     <= DW'(bd_mag);
              w_sign <= b_sign;
              phase  <= PH_B;
              state  <= S_GCD_GO;
            end
            PH_B: begin
              rb_num <= wn[W-1:0];
              rb_den <= wd[W-1:0];
              rb_neg <= r_neg;
              state  <= S_MUL1;
            end
            default: begin
              if (r_fits) begin
                r_num <= 32'($signed(r_sv));
                r_den <= 31'(wd);
              end else begin
                st <= ST_OVF;
              end
              state <= S_FIN;
            end
          endcase
        end
        S_MUL1: begin
          if (cmd == CMD_CMP) begin
            eq    <= (ra_neg == rb_neg) && (ra_num == rb_num) && (ra_den == rb_den);
            state <= S_FIN;
          end else if (cmd > CMD_CMP) begin
            state <= S_FIN;
          end else if (cmd == CMD_DIV && rb_num == '0) begin
            st    <= ST_DIVZ;
            state <= S_FIN;
          end else begin
            t1    <= DW'(m_p);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          t2    <= DW'(m_p);
          state <= S_MUL3;
        end
        S_MUL3: begin
          wd    <= DW'(m_p);
          state <= S_COMB;
        end
        S_COMB: begin
          if (cmd == CMD_ADD || cmd == CMD_SUB) begin
            wn     <= s_mag;
            w_sign <= s_sign;
          end else begin
            wn     <= t1;
            w_sign <= ra_neg ^ rb_neg;
          end
          phase <= PH_R;
          state <= S_GCD_GO;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Port outputs.
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_FIN);
  assign res_num  = r_num;
  assign res_den  = r_den;
  assign is_equal = eq;
  assign status   = st;

  // A result is only shown while the block is busy.
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");

  // Every error yields the fraction zero over one.
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (res_num == 32'd0 && res_den == 31'd1 && !is_equal))
    else $error("error result is not zero over one");

  // A positive compare carries no fraction and no error.
  assert property (@(posedge clk) disable iff (rst)
    (done && is_equal) |-> (status == ST_OK && res_num == 32'd0 && res_den == 31'd1))
    else $error("compare result malformed");

  // A transferred operation makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("operation transfer did not start work");

endmodule
